// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/ssr_pkg.sv =====
// ----------------------------------------------------------------------------
// Schema size registry package
// Field widths, request and status codes and the table entry type.
// ----------------------------------------------------------------------------
package ssr_pkg;

	localparam int MAX_ENTRIES_DEF = 16;
	localparam int ID_W            = 16;
	localparam int SIZE_W          = 16;
	localparam int COUNT_W         = 5;

	localparam logic REQ_REGISTER = 1'b0;
	localparam logic REQ_CHECK    = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_UNKNOWN  = 2'd1,
		ST_FULL     = 2'd2,
		ST_MISMATCH = 2'd3
	} status_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [SIZE_W-1:0] size;
	} entry_t;

endpackage

// ===== sv/ssr_table.sv =====
// ----------------------------------------------------------------------------
// Schema table memory
// Single-port-write, single-read synchronous memory of id and size pairs.
// ----------------------------------------------------------------------------
module ssr_table #(
	parameter int DEPTH = ssr_pkg::MAX_ENTRIES_DEF,
	parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic           clk,
	input  logic [IW-1:0]  rd_addr,
	output ssr_pkg::entry_t rd_data,
	input  logic           wr_en,
	input  logic [IW-1:0]  wr_addr,
	input  ssr_pkg::entry_t wr_data
);

	ssr_pkg::entry_t mem [DEPTH];
	ssr_pkg::entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

// ===== sv/schema_size_registry.sv =====
// ----------------------------------------------------------------------------
// Schema size registry
// Maps schema ids to expected payload sizes; registers, updates and checks.
// ----------------------------------------------------------------------------
// Channel   Direction  Transfer when     Ports
// request   in         start && !busy    req_type, schema, len
// result    out        done              status, expected_size, entry_count
//
// A request walks the filled entries through the table memory, one entry per
// cycle behind the registered table read. Busy ends after a match at some entry,
// after the last filled entry misses, or without any read when the table is
// empty; the result strobe is high in the first cycle with busy low, and a new
// request may be transferred in that same cycle. Reset empties the
// table at once through the fill count. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module schema_size_registry #(
	parameter int MAX_ENTRIES = ssr_pkg::MAX_ENTRIES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         req_type,
	input  logic [ssr_pkg::ID_W-1:0]     schema,
	input  logic [ssr_pkg::SIZE_W-1:0]   len,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [ssr_pkg::SIZE_W-1:0]   expected_size,
	output logic [ssr_pkg::COUNT_W-1:0]  entry_count
);

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	state_t                      state_q;
	logic                        req_q;
	logic [ssr_pkg::ID_W-1:0]    id_q;
	logic [ssr_pkg::SIZE_W-1:0]  size_q;
	logic [CW-1:0]               cnt_q;
	logic [IW-1:0]               ptr_q;
	logic                        pend_s1;
	logic [IW-1:0]               addr_s1;

	logic                        done_q;
	ssr_pkg::status_t            status_q;
	logic [ssr_pkg::SIZE_W-1:0]  expected_q;
	logic [ssr_pkg::COUNT_W-1:0] count_out_q;

	ssr_pkg::entry_t             rd_entry;
	ssr_pkg::entry_t             wr_entry;
	logic                        wr_en;
	logic [IW-1:0]               wr_addr;

	logic                        accept_w;
	logic                        hit_w;
	logic                        last_w;
	logic                        decide_w;
	logic                        more_w;
	ssr_pkg::status_t            status_n;
	logic [ssr_pkg::SIZE_W-1:0]  expected_n;
	logic [CW-1:0]               cnt_n;

	ssr_table #(
		.DEPTH (MAX_ENTRIES),
		.IW    (IW)
	) u_table (
		.clk     (clk),
		.rd_addr (ptr_q),
		.rd_data (rd_entry),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_entry)
	);

	assign busy     = (state_q != S_IDLE);
	assign accept_w = start && !busy;
	assign hit_w    = pend_s1 && (rd_entry.id == id_q);
	assign last_w   = pend_s1 && ((CW'(addr_s1) + CW'(1)) == cnt_q);
	assign decide_w = (state_q == S_SCAN) && ((cnt_q == '0) || hit_w || last_w);
	assign more_w   = (CW'(ptr_q) + CW'(1)) < cnt_q;

	assign wr_entry.id   = id_q;
	assign wr_entry.size = size_q;

	always_comb begin
		status_n   = ssr_pkg::ST_OK;
		expected_n = '0;
		cnt_n      = cnt_q;
		wr_en      = 1'b0;
		wr_addr    = addr_s1;
		if (req_q == ssr_pkg::REQ_REGISTER) begin
			if (hit_w) begin
				wr_en      = decide_w;
				expected_n = size_q;
			end else if (cnt_q == CW'(MAX_ENTRIES)) begin
				status_n = ssr_pkg::ST_FULL;
			end else begin
				wr_en   = decide_w;
				wr_addr = cnt_q[IW-1:0];
				cnt_n   = cnt_q + CW'(1);
			end
		end else begin
			if (!hit_w) begin
				status_n = ssr_pkg::ST_UNKNOWN;
			end else begin
				expected_n = rd_entry.size;
				if (rd_entry.size != size_q) begin
					status_n = ssr_pkg::ST_MISMATCH;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= decide_w;
			case (state_q)
				S_IDLE: begin
					pend_s1 <= 1'b0;
					if (accept_w) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (decide_w) begin
						state_q <= S_IDLE;
						pend_s1 <= 1'b0;
						cnt_q   <= cnt_n;
					end else begin
						pend_s1 <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					pend_s1 <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept_w) begin
			req_q  <= req_type;
			id_q   <= schema;
			size_q <= len;
			ptr_q  <= '0;
		end else if ((state_q == S_SCAN) && more_w) begin
			ptr_q <= ptr_q + IW'(1);
		end
		addr_s1 <= ptr_q;
		if (decide_w) begin
			status_q    <= status_n;
			expected_q  <= expected_n;
			count_out_q <= ssr_pkg::COUNT_W'(cnt_n);
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign expected_size = expected_q;
	assign entry_count   = count_out_q;

	`ASSERT_IMP(a_done_after_busy, $fell(busy), done)
	`ASSERT_IMP(a_busy_before_done, done, $fell(busy))
	`ASSERT_IMP(a_count_bound, 1'b1, cnt_q <= CW'(MAX_ENTRIES))
	`ASSERT_IMP(a_scan_in_range, pend_s1, CW'(addr_s1) < cnt_q)
	`ASSERT_IMP(a_full_only_when_full, done && (status_q == ssr_pkg::ST_FULL), cnt_q == CW'(MAX_ENTRIES))
	`ASSERT_NXT(a_append_grows, decide_w && (cnt_n != cnt_q), cnt_q == $past(cnt_q) + CW'(1))

endmodule
